// File: src/ps2_set2_scan_decoder_assert.svh
// ----------------------------------------------------------------------------
// PS/2 set 2 scan decoder assertion macros
// Shared macros for concurrent checks that are clocked on a given clock and off in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_SET2_SCAN_DECODER_ASSERT_SVH
`define PS2_SET2_SCAN_DECODER_ASSERT_SVH

// A check that is off while reset is asserted.
`define PS2S2_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A check for the cycle after a condition, off while reset is asserted.
`define PS2S2_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    `PS2S2_ASSERT(label, clk, rstn, (cond) |=> (prop), msg)

`endif

// File: src/ps2s2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 set 2 scan decoder package
// Types, constants and key tables for the decoder and its event ring.
// ----------------------------------------------------------------------------
package ps2s2_pkg;

    localparam int RING_DEPTH = 32;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int WAIT_W     = 5;
    localparam int WAIT_MAX   = 31;
    localparam int CNT_W      = (PTR_W + 1 > WAIT_W) ? PTR_W + 1 : WAIT_W;

    localparam logic [7:0] CODE_E0     = 8'hE0;
    localparam logic [7:0] CODE_F0     = 8'hF0;
    localparam logic [7:0] CODE_LSHIFT = 8'h12;
    localparam logic [7:0] CODE_RSHIFT = 8'h59;
    localparam logic [7:0] CODE_CTRL   = 8'h14;
    localparam logic [7:0] CODE_ALT    = 8'h11;
    localparam logic [7:0] CODE_CAPS   = 8'h58;

    localparam int MOD_SHIFT_BIT = 0;
    localparam int MOD_CTRL_BIT  = 1;
    localparam int MOD_ALT_BIT   = 2;
    localparam int MOD_CAPS_BIT  = 3;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_E0   = 2'd1,
        ST_F0   = 2'd2,
        ST_E0F0 = 2'd3
    } prefix_state_t;

    typedef struct packed {
        logic [3:0] mods;
        logic       pressed;
        logic       extended;
        logic [7:0] scan;
    } ring_entry_t;

    localparam int ENTRY_W = $bits(ring_entry_t);

    function automatic logic is_normal(input logic [7:0] code);
        logic hit;
        unique case (code)
            8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
            8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
            8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A,
            8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46,
            8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09,
            8'h78, 8'h07, 8'h5A, 8'h66, 8'h0D, 8'h76, 8'h29,
            8'h4E, 8'h55, 8'h54, 8'h5B, 8'h5D, 8'h4C, 8'h52, 8'h41, 8'h49, 8'h4A,
            8'h0E, 8'h12, 8'h59, 8'h14, 8'h11, 8'h58: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_extended(input logic [7:0] code);
        logic hit;
        unique case (code)
            8'h75, 8'h72, 8'h6B, 8'h74, 8'h6C, 8'h69,
            8'h7D, 8'h7A, 8'h70, 8'h71, 8'h14, 8'h11: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(RING_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

// File: src/ps2s2_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ps2s2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/ps2_set2_scan_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 set 2 scan decoder
// Prefix tracking, modifier state and an event ring with read requests.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle. A scan byte word updates the
// prefix machine and modifier bits in the cycle it is accepted and, for a
// known key, writes one event into the ring RAM; it returns nothing. A read
// word pops one event if the ring holds one; its result is on the master
// side in the cycle after acceptance, via the registered RAM read. Sustained
// rate is one word per cycle while m_tready is high; while a result is held
// by a low m_tready, s_tready is low. The ring holds RING_DEPTH - 1 events,
// needs no clearing after reset, and a push to a full ring is dropped.
// ----------------------------------------------------------------------------
`include "ps2_set2_scan_decoder_assert.svh"

module ps2_set2_scan_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] key_scan, [8] key_extended, [9] key_pressed, [13:10] event_modifiers,
    // [17:14] current_modifiers, [22:18] events_waiting, [23] zero
    output logic [23:0] m_tdata,
    output logic [0:0]  m_tuser    // [0] event_valid
);

    localparam int PTR_W  = ps2s2_pkg::PTR_W;
    localparam int CNT_W  = ps2s2_pkg::CNT_W;
    localparam int WAIT_W = ps2s2_pkg::WAIT_W;

    ps2s2_pkg::prefix_state_t prefix_reg, prefix_next;
    logic [3:0]       mod_reg, mod_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;

    logic              out_valid_reg;
    logic              ev_valid_reg;
    logic [3:0]        cur_mod_reg;
    logic [WAIT_W-1:0] waiting_reg, waiting_next;

    logic s_acc, scan_acc, read_acc, ring_empty, ring_full, pop;
    logic code_done, code_ext, code_press, code_known, push;
    logic [CNT_W-1:0] count_w;
    ps2s2_pkg::ring_entry_t wr_entry, rd_entry;

    assign s_tready   = !out_valid_reg || m_tready;
    assign s_acc      = s_tvalid && s_tready;
    assign scan_acc   = s_acc && (s_tuser[0] == ps2s2_pkg::REQ_SCAN);
    assign read_acc   = s_acc && (s_tuser[0] == ps2s2_pkg::REQ_READ);
    assign ring_empty = (rd_ptr_reg == wr_ptr_reg);
    assign ring_full  = (ps2s2_pkg::ring_next(wr_ptr_reg) == rd_ptr_reg);
    assign pop        = read_acc && !ring_empty;

    // Prefix machine: next state.
    always_comb begin
        prefix_next = prefix_reg;
        if (scan_acc) begin
            unique case (prefix_reg)
                ps2s2_pkg::ST_IDLE: begin
                    if (s_tdata == ps2s2_pkg::CODE_E0) begin
                        prefix_next = ps2s2_pkg::ST_E0;
                    end else if (s_tdata == ps2s2_pkg::CODE_F0) begin
                        prefix_next = ps2s2_pkg::ST_F0;
                    end
                end
                ps2s2_pkg::ST_E0: begin
                    if (s_tdata == ps2s2_pkg::CODE_F0) begin
                        prefix_next = ps2s2_pkg::ST_E0F0;
                    end else begin
                        prefix_next = ps2s2_pkg::ST_IDLE;
                    end
                end
                ps2s2_pkg::ST_F0, ps2s2_pkg::ST_E0F0: begin
                    prefix_next = ps2s2_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Prefix machine: which byte completes a code, and of what kind.
    always_comb begin
        code_done  = 1'b0;
        code_ext   = 1'b0;
        code_press = 1'b0;
        unique case (prefix_reg)
            ps2s2_pkg::ST_IDLE: begin
                code_done  = (s_tdata != ps2s2_pkg::CODE_E0) &&
                             (s_tdata != ps2s2_pkg::CODE_F0);
                code_press = 1'b1;
            end
            ps2s2_pkg::ST_E0: begin
                code_done  = (s_tdata != ps2s2_pkg::CODE_F0);
                code_ext   = 1'b1;
                code_press = 1'b1;
            end
            ps2s2_pkg::ST_F0: begin
                code_done = 1'b1;
            end
            ps2s2_pkg::ST_E0F0: begin
                code_done = 1'b1;
                code_ext  = 1'b1;
            end
        endcase
    end

    assign code_known = code_ext ? ps2s2_pkg::is_extended(s_tdata)
                                 : ps2s2_pkg::is_normal(s_tdata);

    always_comb begin
        mod_next = mod_reg;
        if (scan_acc && code_done && code_known) begin
            priority if (!code_ext && (s_tdata == ps2s2_pkg::CODE_LSHIFT ||
                                       s_tdata == ps2s2_pkg::CODE_RSHIFT)) begin
                mod_next[ps2s2_pkg::MOD_SHIFT_BIT] = code_press;
            end else if (s_tdata == ps2s2_pkg::CODE_CTRL) begin
                mod_next[ps2s2_pkg::MOD_CTRL_BIT] = code_press;
            end else if (s_tdata == ps2s2_pkg::CODE_ALT) begin
                mod_next[ps2s2_pkg::MOD_ALT_BIT] = code_press;
            end else if (!code_ext && s_tdata == ps2s2_pkg::CODE_CAPS) begin
                mod_next[ps2s2_pkg::MOD_CAPS_BIT] = mod_reg[ps2s2_pkg::MOD_CAPS_BIT] ^
                                                     code_press;
            end else begin
                mod_next = mod_reg;
            end
        end
    end

    // The modifier update still happens when the ring is full.
    assign push = scan_acc && code_done && code_known && !ring_full;

    assign wr_entry.scan     = s_tdata;
    assign wr_entry.extended = code_ext;
    assign wr_entry.pressed  = code_press;
    assign wr_entry.mods     = mod_next;

    assign wr_ptr_next = push ? ps2s2_pkg::ring_next(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next = pop  ? ps2s2_pkg::ring_next(rd_ptr_reg) : rd_ptr_reg;

    // Occupancy after the pop; no push happens in a read cycle.
    always_comb begin
        if (wr_ptr_reg >= rd_ptr_next) begin
            count_w = CNT_W'(wr_ptr_reg) - CNT_W'(rd_ptr_next);
        end else begin
            count_w = CNT_W'(wr_ptr_reg) + CNT_W'(ps2s2_pkg::RING_DEPTH) -
                      CNT_W'(rd_ptr_next);
        end
        if (count_w > CNT_W'(ps2s2_pkg::WAIT_MAX)) begin
            waiting_next = WAIT_W'(ps2s2_pkg::WAIT_MAX);
        end else begin
            waiting_next = count_w[WAIT_W-1:0];
        end
    end

    ps2s2_ram #(
        .WIDTH (ps2s2_pkg::ENTRY_W),
        .DEPTH (ps2s2_pkg::RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_entry),
        .rd_en   (pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg    <= ps2s2_pkg::ST_IDLE;
            mod_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            prefix_reg <= prefix_next;
            mod_reg    <= mod_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (read_acc) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (read_acc) begin
            ev_valid_reg <= !ring_empty;
            cur_mod_reg  <= mod_reg;
            waiting_reg  <= waiting_next;
        end
    end

    // Event fields read as zero when the ring was empty.
    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = ev_valid_reg;
    assign m_tdata    = {1'b0, waiting_reg, cur_mod_reg,
                         ev_valid_reg ? rd_entry : {ps2s2_pkg::ENTRY_W{1'b0}}};

    `PS2S2_ASSERT_NEXT(a_pop_gives_event, aclk, aresetn, read_acc && !ring_empty,
        m_tvalid && m_tuser[0], "read of a filled ring did not return an event")
    `PS2S2_ASSERT_NEXT(a_scan_no_result, aclk, aresetn, scan_acc && !out_valid_reg,
        !m_tvalid, "scan byte produced a result")
    `PS2S2_ASSERT_NEXT(a_mods_only_on_scan, aclk, aresetn, !scan_acc,
        $stable(mod_reg), "modifier bits changed without a scan byte")
    `PS2S2_ASSERT_NEXT(a_empty_read_holds, aclk, aresetn, read_acc && ring_empty,
        $stable(rd_ptr_reg) && !m_tuser[0], "read of an empty ring moved the pointer")

endmodule
